// ----- rtl/vvpc_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the vertex view/projection/clip block
// no dependencies
package vvpc_pkg;

   localparam int COEF_COUNT = 24;
   localparam int IDX_W      = 5;

   // first projection coefficient, end of the store
   localparam logic [IDX_W-1:0] PROJ_BASE = 5'd12;
   localparam logic [IDX_W-1:0] COEF_END  = 5'd24;

   // register indexes on the csr port
   localparam logic REG_NEAR = 1'b0;
   localparam logic REG_FAR  = 1'b1;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_PROJECT = 1'b1
   } cmd_type;

   // sideband that rides along the divider stages
   typedef struct packed {
      logic vld;
      logic vis;
   } tag_type;

endpackage

// ----- rtl/vvpc_req_if.sv -----
`timescale 1ns / 1ps
// request channel: one command item (coefficient load or vertex)
// depends on vvpc_pkg
interface vvpc_req_if;
   import vvpc_pkg::*;

   logic               valid;
   logic               ready;
   cmd_type            command;
   logic [4:0]         coef_index;
   logic signed [31:0] coef_value;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;
   logic signed [31:0] vertex_z;

   modport source (output valid, command, coef_index, coef_value, vertex_x, vertex_y,
                   vertex_z, input ready);
   modport sink (input valid, command, coef_index, coef_value, vertex_x, vertex_y,
                 vertex_z, output ready);
endinterface

// ----- rtl/vvpc_rsp_if.sv -----
`timescale 1ns / 1ps
// response channel: one projected screen point
// no dependencies
interface vvpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   logic               visible;

   modport source (output valid, screen_x, screen_y, visible, input ready);
   modport sink (input valid, screen_x, screen_y, visible, output ready);
endinterface

// ----- rtl/vvpc_div.sv -----
`timescale 1ns / 1ps
// two-lane pipelined restoring divider, one quotient bit per stage, shared divisor
// depends on vvpc_pkg
module vvpc_div #(
   parameter int FRAC_BITS = 16,
   parameter int WIDE_W    = 50
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  vvpc_pkg::tag_type        tag_i,
   input  logic signed [WIDE_W-1:0] num_x,
   input  logic signed [WIDE_W-1:0] num_y,
   input  logic [WIDE_W-1:0]        den,
   output vvpc_pkg::tag_type        tag_o,
   output logic signed [31:0]       quo_x,
   output logic signed [31:0]       quo_y
);
   import vvpc_pkg::*;

   localparam int QB = 31;
   localparam int NS = QB;
   localparam int DW = WIDE_W + QB;

   logic [DW-1:0]     rem_ff [2][NS+1];
   logic [QB-1:0]     q_ff   [2][NS+1];
   logic              neg_ff [2][NS+1];
   logic              ovf_ff [2][NS+1];
   logic [WIDE_W-1:0] den_ff [NS+1];
   tag_type           tag_ff [NS+1];

   logic signed [WIDE_W-1:0] num [2];
   logic [WIDE_W-1:0]        mag_in [2];
   logic                     ovf_in [2];
   logic [31:0]              res [2];

   assign num[0] = num_x;
   assign num[1] = num_y;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag_in[l] = num[l][WIDE_W-1] ? WIDE_W'(-num[l]) : WIDE_W'(num[l]);
         // quotient reaches 2^31 exactly when mag >= den << (31 - frac)
         ovf_in[l] = DW'(mag_in[l]) >= (DW'(den) << (QB - FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[0] <= '0;
      end else if (en) begin
         tag_ff[0] <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0] <= den;
         for (int l = 0; l < 2; l++) begin
            rem_ff[l][0] <= DW'(mag_in[l]) << FRAC_BITS;
            q_ff[l][0]   <= '0;
            neg_ff[l][0] <= num[l][WIDE_W-1];
            ovf_ff[l][0] <= ovf_in[l];
         end
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int BIT = QB - 1 - k;
      logic [DW-1:0] sub;

      assign sub = DW'(den_ff[k]) << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k+1] <= '0;
         end else if (en) begin
            tag_ff[k+1] <= tag_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1] <= den_ff[k];
            for (int l = 0; l < 2; l++) begin
               neg_ff[l][k+1] <= neg_ff[l][k];
               ovf_ff[l][k+1] <= ovf_ff[l][k];
               if (rem_ff[l][k] >= sub) begin
                  rem_ff[l][k+1] <= rem_ff[l][k] - sub;
                  q_ff[l][k+1]   <= q_ff[l][k] | (QB'(1) << BIT);
               end else begin
                  rem_ff[l][k+1] <= rem_ff[l][k];
                  q_ff[l][k+1]   <= q_ff[l][k];
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (ovf_ff[l][NS]) begin
            res[l] = neg_ff[l][NS] ? 32'h8000_0000 : 32'h7fff_ffff;
         end else if (neg_ff[l][NS]) begin
            res[l] = -{1'b0, q_ff[l][NS]};
         end else begin
            res[l] = {1'b0, q_ff[l][NS]};
         end
      end
   end

   assign tag_o = tag_ff[NS];
   assign quo_x = res[0];
   assign quo_y = res[1];

endmodule

// ----- rtl/vertex_view_project_clip.sv -----
`timescale 1ns / 1ps
// Vertex transform, near/far depth rejection and perspective divide; one item per
// cycle. A projected point reaches rsp after its item is accepted and passes through four
// transform stages, a 32-stage divider (an input stage, then 31 stages that each yield
// one quotient bit), and the output register. Coefficient loads give no result. The
// whole pipeline advances whenever the output register is empty or being taken, so
// the sustained rate is one item per cycle while rsp keeps up. No clearing pass after
// reset.
// depends on vvpc_pkg, vvpc_req_if, vvpc_rsp_if, vvpc_div
module vertex_view_project_clip #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   vvpc_req_if.sink    req_ch,
   vvpc_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vvpc_pkg::*;

   localparam int WIDE_W   = 66 - FRAC_BITS;
   localparam int WMIN_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int WMIN     = (WMIN_RAW < 1) ? 1 : WMIN_RAW;
   localparam logic signed [31:0]       ONE    = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] WMIN_W = WIDE_W'(WMIN);

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if ((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31])) begin
         return v[31:0];
      end
      return v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   // csr
   logic [30:0] near_ff, far_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= 31'd65536;
         far_ff  <= 31'd655360000;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_NEAR: near_ff <= csr_pwdata[30:0];
            REG_FAR:  far_ff  <= csr_pwdata[30:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_NEAR: csr_prdata = {1'b0, near_ff};
         REG_FAR:  csr_prdata = {1'b0, far_ff};
         default:  csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic rsp_vld_ff;
   logic adv, acc_in;

   assign adv          = !rsp_vld_ff || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign acc_in       = req_ch.valid && adv;

   // coefficient store
   logic signed [31:0] coef_ff [COEF_COUNT];
   logic mv_wr, pj_wr;

   // stage registers
   logic               s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   cmd_type            s1_cmd_ff, s2_cmd_ff;
   logic [IDX_W-1:0]   s1_idx_ff, s2_idx_ff;
   logic signed [31:0] s1_val_ff, s2_val_ff;
   logic signed [63:0] s1_prod_ff [3][3];
   logic signed [31:0] s1_off_ff [3];
   logic signed [31:0] s2_cam_ff [3];
   logic               s3_vis_ff, s4_vis_ff;
   logic signed [63:0] s3_prod_ff [3][3];
   logic signed [31:0] s3_off_ff [3];
   logic signed [WIDE_W-1:0] s4_p_ff [3];

   logic signed [31:0]       vtx [3];
   logic signed [63:0]       s1_prod_in [3][3];
   logic signed [WIDE_W-1:0] s2_acc [3];
   logic signed [31:0]       s2_cam_in [3];
   logic signed [33:0]       near_sum, far_sum;
   logic                     s3_vis_in;
   logic signed [63:0]       s3_prod_in [3][3];
   logic signed [WIDE_W-1:0] s4_acc [3];

   assign mv_wr = acc_in && req_ch.command == CMD_LOAD && req_ch.coef_index < PROJ_BASE;
   // projection loads land when they pass the stage that reads the projection matrix
   assign pj_wr = adv && s2_vld_ff && s2_cmd_ff == CMD_LOAD
                  && s2_idx_ff >= PROJ_BASE && s2_idx_ff < COEF_END;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= (i == 0 || i == 4 || i == 8 || i == 12 || i == 16 || i == 23)
                          ? ONE : '0;
         end
      end else begin
         if (mv_wr) begin
            coef_ff[req_ch.coef_index] <= req_ch.coef_value;
         end
         if (pj_wr) begin
            coef_ff[s2_idx_ff] <= s2_val_ff;
         end
      end
   end

   // stage 1: model-view products
   assign vtx[0] = req_ch.vertex_x;
   assign vtx[1] = req_ch.vertex_y;
   assign vtx[2] = req_ch.vertex_z;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < 3; r++) begin
            s1_prod_in[c][r] = 64'(vtx[r]) * 64'(coef_ff[r*3+c]);
         end
      end
   end

   // stage 2: camera-space sums
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s2_acc[c] = WIDE_W'(s1_off_ff[c]);
         for (int r = 0; r < 3; r++) begin
            s2_acc[c] = s2_acc[c] + WIDE_W'(s1_prod_ff[c][r] >>> FRAC_BITS);
         end
         s2_cam_in[c] = sat32(s2_acc[c]);
      end
   end

   // stage 3: depth test and projection products
   assign near_sum  = 34'(s2_cam_ff[2]) + $signed({3'b000, near_ff});
   assign far_sum   = 34'(s2_cam_ff[2]) + $signed({3'b000, far_ff});
   assign s3_vis_in = near_sum[33] && !far_sum[33];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int r = 0; r < 3; r++) begin
            s3_prod_in[k][r] = 64'(s2_cam_ff[r]) * 64'(coef_ff[PROJ_BASE + r*3 + k]);
         end
      end
   end

   // stage 4: projected sums, w floor
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s4_acc[k] = WIDE_W'(s3_off_ff[k]);
         for (int r = 0; r < 3; r++) begin
            s4_acc[k] = s4_acc[k] + WIDE_W'(s3_prod_ff[k][r] >>> FRAC_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_ch.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff && s2_cmd_ff == CMD_PROJECT;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff  <= req_ch.command;
         s1_idx_ff  <= req_ch.coef_index;
         s1_val_ff  <= req_ch.coef_value;
         s1_prod_ff <= s1_prod_in;
         for (int c = 0; c < 3; c++) begin
            s1_off_ff[c] <= coef_ff[9+c];
            s3_off_ff[c] <= coef_ff[PROJ_BASE + 9 + c];
         end
         s2_cmd_ff  <= s1_cmd_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_val_ff  <= s1_val_ff;
         s2_cam_ff  <= s2_cam_in;
         s3_vis_ff  <= s3_vis_in;
         s3_prod_ff <= s3_prod_in;
         s4_vis_ff  <= s3_vis_ff;
         s4_p_ff[0] <= s4_acc[0];
         s4_p_ff[1] <= s4_acc[1];
         s4_p_ff[2] <= (s4_acc[2] < WMIN_W) ? WMIN_W : s4_acc[2];
      end
   end

   // divide
   tag_type            div_tag_in, div_tag;
   logic signed [31:0] div_x, div_y;

   assign div_tag_in = '{vld: s4_vld_ff, vis: s4_vis_ff};

   vvpc_div #(
      .FRAC_BITS (FRAC_BITS),
      .WIDE_W    (WIDE_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .tag_i (div_tag_in),
      .num_x (s4_p_ff[0]),
      .num_y (s4_p_ff[1]),
      .den   (WIDE_W'(unsigned'(s4_p_ff[2]))),
      .tag_o (div_tag),
      .quo_x (div_x),
      .quo_y (div_y)
   );

   // output register
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_vis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= div_tag.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_x_ff   <= div_tag.vis ? div_x : '0;
         rsp_y_ff   <= div_tag.vis ? div_y : '0;
         rsp_vis_ff <= div_tag.vis;
      end
   end

   assign rsp_ch.valid    = rsp_vld_ff;
   assign rsp_ch.screen_x = rsp_x_ff;
   assign rsp_ch.screen_y = rsp_y_ff;
   assign rsp_ch.visible  = rsp_vis_ff;

   // a rejected point always leaves with a zero screen position
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_vis_ff) |-> (rsp_x_ff == '0 && rsp_y_ff == '0))
      else $error("rejected item carries nonzero screen position");

   // coefficient loads never reach the projection stages
   a_load_dropped : assert property (@(posedge clock) disable iff (reset)
      (adv && s2_vld_ff && s2_cmd_ff == CMD_LOAD) |=> !s3_vld_ff)
      else $error("load item entered projection stages");

   // a stall freezes the pipeline
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(s1_vld_ff) && $stable(s4_vld_ff) && $stable(div_tag)))
      else $error("pipeline moved during stall");

endmodule
